[hdl/acal_pkg.sv]
// ----------------------------------------------------------------------------
// acal_pkg
// shared codes of the aligned chunk allocator: commands and status values
// ----------------------------------------------------------------------------
`default_nettype none
package acal_pkg;
	localparam int CHUNK_BYTES = 4096;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;

	localparam int START_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 10;
endpackage
`default_nettype wire

[hdl/acal_map_mem.sv]
// ----------------------------------------------------------------------------
// acal_map_mem
// free map storage, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module acal_map_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = 5
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[hdl/acal_word_eval.sv]
// ----------------------------------------------------------------------------
// acal_word_eval
// per-word logic: aligned fit search for allocate and run masking for update
// ----------------------------------------------------------------------------
`default_nettype none
module acal_word_eval #(
	parameter int W  = 32,
	parameter int IW = 12
) (
	input  wire logic [W-1:0]  word,
	input  wire logic [IW-1:0] base,
	input  wire logic [IW-1:0] align_mask,
	input  wire logic          carry_in,
	input  wire logic [IW-1:0] lo,
	input  wire logic [IW-1:0] hi,
	input  wire logic          set_free,
	output logic               found,
	output logic [IW-1:0]      end_idx,
	output logic               carry_out,
	output logic [W-1:0]       new_word
);
	logic [W-1:0]  ok;
	logic [W-1:0]  is_end;
	logic [W-1:0]  run_mask;

	always_comb begin
		logic [IW-1:0] idx;
		logic [IW-1:0] off;
		logic          all_free;
		for (int b = 0; b < W; b++) begin
			idx = base + IW'(b);
			off = idx & align_mask;
			all_free = 1'b1;
			// group bits of this word up to b must all be free
			for (int k = 0; k < W; k++) begin
				if (k <= b && (off > IW'(b) || IW'(k) >= IW'(b) - off)) begin
					all_free = all_free & word[k];
				end
			end
			ok[b]       = all_free & ((off > IW'(b)) ? carry_in : 1'b1);
			is_end[b]   = (off == align_mask);
			run_mask[b] = (idx >= lo) && (idx <= hi);
		end
	end

	always_comb begin
		found   = 1'b0;
		end_idx = '0;
		for (int b = W - 1; b >= 0; b--) begin
			if (ok[b] && is_end[b]) begin
				found   = 1'b1;
				end_idx = base + IW'(b);
			end
		end
	end

	assign carry_out = ok[W-1];
	assign new_word  = set_free ? (word | run_mask) : (word & ~run_mask);
endmodule
`default_nettype wire

[hdl/aligned_chunk_allocator.sv]
// ----------------------------------------------------------------------------
// aligned_chunk_allocator
// first-fit aligned allocator of 4 KiB chunks over a word-wide free map
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_*       in         tuser: cmd; tdata: start_chunk, chunk_count
// m_*       out        tdata: status, chunk_index
//
// after reset a clearing pass writes every map word before the first
// transaction is taken
// free: one map word per cycle from word 0 to the last word of the run
// allocate: one word per cycle of scan up to the fit, then one word per cycle
// back down over the run
// one item in flight; the next is taken while the result waits on m_*
// ----------------------------------------------------------------------------
`default_nettype none
module aligned_chunk_allocator #(
	parameter int NUM_CHUNKS    = 1024,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // start_chunk[9:0], chunk_count[20:10], zeros
	input  wire logic        s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // status[1:0], chunk_index[11:2], zeros
);
	import acal_pkg::*;

	localparam int W     = MAP_WORD_BITS;
	localparam int DEPTH = (NUM_CHUNKS + W - 1) / W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IWR   = $clog2(NUM_CHUNKS + 2 * W) + 1;
	localparam int IW    = (IWR > 12) ? IWR : 12;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RMW  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [AW-1:0]       rd_addr_q;
	logic [IW-1:0]       rd_base_q;
	logic                issue_q;
	logic                up_q;
	logic                set_q;
	logic [IW-1:0]       lo_q, hi_q, mask_q;
	logic                carry_q;
	logic                v_s1, last_s1;
	logic [AW-1:0]       addr_s1;
	logic [IW-1:0]       base_s1;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  index_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [INDEX_W-1:0]  m_index_q;
	logic                m_valid_q;

	logic [W-1:0]  rdata, new_word, wdata;
	logic          we;
	logic [AW-1:0] waddr;
	logic          found, carry_out;
	logic [IW-1:0] end_idx;

	logic                in_cmd;
	logic [START_W-1:0]  in_start;
	logic [COUNT_W-1:0]  in_count;
	logic [IW-1:0]       cnt, free_end;
	logic                accept, issue, last_issue, out_load;

	assign in_start = s_tdata[9:0];
	assign in_count = s_tdata[20:10];
	assign in_cmd   = s_tuser;
	assign cnt      = (in_count == '0) ? IW'(1) : IW'(in_count);
	assign free_end = IW'(in_start) + cnt;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign issue    = issue_q && (state_q == S_RMW || state_q == S_SCAN);
	assign out_load = (state_q == S_FIN) && (!m_valid_q || m_tready);

	always_comb begin
		if (state_q == S_SCAN) begin
			last_issue = (rd_addr_q == AW'(DEPTH - 1));
		end else if (up_q) begin
			last_issue = (rd_base_q + IW'(W) > hi_q) || (rd_addr_q == AW'(DEPTH - 1));
		end else begin
			last_issue = (rd_base_q <= lo_q) || (rd_addr_q == '0);
		end
	end

	assign we    = (state_q == S_CLR) || (state_q == S_RMW && v_s1);
	assign waddr = (state_q == S_CLR) ? rd_addr_q : addr_s1;
	assign wdata = (state_q == S_CLR) ? '0 : new_word;

	acal_map_mem #(.DEPTH(DEPTH), .WIDTH(W), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	acal_word_eval #(.W(W), .IW(IW)) u_eval (
		.word       (rdata),
		.base       (base_s1),
		.align_mask (mask_q),
		.carry_in   (carry_q),
		.lo         (lo_q),
		.hi         (hi_q),
		.set_free   (set_q),
		.found      (found),
		.end_idx    (end_idx),
		.carry_out  (carry_out),
		.new_word   (new_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			rd_addr_q <= '0;
			rd_base_q <= '0;
			issue_q   <= 1'b0;
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			v_s1 <= issue;
			if (issue) begin
				issue_q <= !last_issue;
				if (up_q || state_q == S_SCAN) begin
					rd_addr_q <= rd_addr_q + AW'(1);
					rd_base_q <= rd_base_q + IW'(W);
				end else begin
					rd_addr_q <= rd_addr_q - AW'(1);
					rd_base_q <= rd_base_q - IW'(W);
				end
			end

			case (state_q)
				S_CLR: begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (rd_addr_q == AW'(DEPTH - 1)) begin
						rd_addr_q <= '0;
						state_q   <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_addr_q <= '0;
						rd_base_q <= '0;
						issue_q   <= 1'b1;
						if (in_cmd == CMD_FREE) begin
							state_q <= (free_end > IW'(NUM_CHUNKS)) ? S_FIN : S_RMW;
						end else if ((cnt & (cnt - IW'(1))) != '0
								|| cnt > IW'(NUM_CHUNKS)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (v_s1) begin
						if (found) begin
							// mark the run used walking down from the word where it ends
							v_s1      <= 1'b0;
							issue_q   <= 1'b1;
							rd_addr_q <= addr_s1;
							rd_base_q <= base_s1;
							state_q   <= S_RMW;
						end else if (last_s1) begin
							state_q <= S_FIN;
						end
					end
				end
				S_RMW: begin
					if (v_s1 && last_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= rd_addr_q;
			base_s1 <= rd_base_q;
			last_s1 <= last_issue;
		end
		if (accept) begin
			carry_q  <= 1'b0;
			mask_q   <= cnt - IW'(1);
			index_q  <= '0;
			status_q <= ST_DONE;
			up_q     <= 1'b1;
			set_q    <= 1'b1;
			lo_q     <= IW'(in_start);
			hi_q     <= free_end - IW'(1);
			if (in_cmd == CMD_FREE) begin
				if (free_end > IW'(NUM_CHUNKS)) begin
					status_q <= ST_BAD;
				end
			end else if ((cnt & (cnt - IW'(1))) != '0 || cnt > IW'(NUM_CHUNKS)) begin
				status_q <= ST_BAD;
			end
		end
		if (state_q == S_SCAN && v_s1) begin
			carry_q <= carry_out;
			if (found) begin
				lo_q    <= end_idx - mask_q;
				hi_q    <= end_idx;
				set_q   <= 1'b0;
				up_q    <= 1'b0;
				index_q <= INDEX_W'(end_idx - mask_q);
			end else if (last_s1) begin
				status_q <= ST_NOFIT;
			end
		end
		if (out_load) begin
			m_status_q <= status_q;
			m_index_q  <= index_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, m_index_q, m_status_q};
endmodule
`default_nettype wire

[hdl/acal_checker.sv]
// ----------------------------------------------------------------------------
// acal_checker
// port-level checks of the aligned chunk allocator
// ----------------------------------------------------------------------------
`default_nettype none
module acal_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [23:0] s_tdata,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	import acal_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ST_DONE || m_tdata[1:0] == ST_NOFIT
			|| m_tdata[1:0] == ST_BAD))
		else $error("unknown status code");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != ST_DONE) |-> (m_tdata[11:2] == '0))
		else $error("failed request returned nonzero index");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction taken while one is in work");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tuser)))
		else $error("request changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");
endmodule

bind aligned_chunk_allocator acal_checker u_acal_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
